// ----- hw/rtl/bitmap_page_allocator_next_fit_assert.svh -----
// assertion macros for the checker file of the page allocator
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef BITMAP_PAGE_ALLOCATOR_NEXT_FIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_NEXT_FIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BPANF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BPANF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpanf_pkg.sv -----
// shared types and constants for the next-fit bitmap page allocator
// no dependencies; used by the top level and its checker
package bpanf_pkg;

    localparam int DEF_MAX_PAGES = 32768;
    localparam int WORD_BITS     = 32;

    localparam logic [31:0] FULL_WORD   = 32'hFFFF_FFFF;
    localparam logic [15:0] COUNT_RESET = 16'd32768;

    typedef enum logic [1:0] {
        OP_FREE  = 2'd0,
        OP_MARK  = 2'd1,
        OP_ALLOC = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] page_number;
    } bpanf_in_t;

    typedef struct packed {
        logic        alloc_ok;
        logic [14:0] alloc_page;
        logic        out_of_range;
    } bpanf_out_t;

endpackage

// ----- hw/rtl/bitmap_page_allocator_next_fit.sv -----
// next-fit bitmap page allocator: bitmap memory, scan sequencer and output register
// depends on bpanf_pkg
//
// channel  | signals                      | direction | payload
// ---------+------------------------------+-----------+------------------------------
// in       | in_valid / in_ready          | into      | bpanf_in_t  (op, page_number)
// out      | out_valid / out_ready        | out of    | bpanf_out_t (ok, page, range)
// cfg      | cfg_wr_en                    | into      | cfg_wr_data = page_count
//
// free and mark: accept, read, modify-write and result, in that order
// allocate: accept, hint modulo word count, scan and result; the scan reads one word per cycle
// out of range, empty count or unused op: accept, then result
// after reset the bitmap is filled with ones, one word at a time,
// during which no request is taken; page_count writes are taken at any time
// a stalled result waits in the output register while the next request is taken
module bitmap_page_allocator_next_fit
    import bpanf_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  bpanf_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output bpanf_out_t  out_data
);

    localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int NW_W  = AW + 1;
    localparam int MC_W  = $clog2(AW + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_RD,
        ST_WR,
        ST_FINISH
    } state_t;

    // bitmap memory
    logic [31:0]   mem [WORDS];
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    state_t        state_reg,     state_next;
    logic [15:0]   count_reg,     count_next;
    logic [AW-1:0] hint_reg,      hint_next;
    logic [1:0]    op_reg,        op_next;
    logic [19:0]   page_reg,      page_next;
    logic [AW-1:0] clr_idx_reg,   clr_idx_next;
    logic [AW-1:0] dvd_reg,       dvd_next;
    logic [NW_W-1:0] rem_reg,     rem_next;
    logic [MC_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic [AW-1:0] iss_idx_reg,   iss_idx_next;
    logic [NW_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [AW-1:0] chk_idx_reg,   chk_idx_next;
    logic [NW_W-1:0] chk_cnt_reg, chk_cnt_next;
    logic          rd_vld_reg,    rd_vld_next;
    bpanf_out_t    res_reg,       res_next;
    logic          out_valid_reg, out_valid_next;
    bpanf_out_t    out_data_reg,  out_data_next;

    logic [15:0]     count_eff;
    logic [16:0]     nwords_raw;
    logic [NW_W-1:0] nwords;
    logic [NW_W-1:0] nwords_last;
    logic [AW-1:0]   rmw_word;
    logic [31:0]     rmw_mask;
    logic [NW_W:0]   rem_sh;
    logic [NW_W:0]   rem_sub;
    logic [4:0]      chk_bit;
    logic [AW+4:0]   chk_pg;
    logic            chk_fit;
    logic            issue;

    function automatic logic [4:0] lowest_clear(input logic [31:0] w);
        logic [4:0] b;
        b = 5'd31;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // effective page count saturates at the bitmap size
    always_comb begin
        if ({5'd0, count_reg} > 21'(MAX_PAGES)) begin
            count_eff = 16'(MAX_PAGES);
        end
        else begin
            count_eff = count_reg;
        end
    end

    assign nwords_raw  = (17'(count_eff) + 17'd31) >> 5;
    assign nwords      = NW_W'(nwords_raw);
    assign nwords_last = nwords - NW_W'(1);

    assign rmw_word = page_reg[5 +: AW];
    assign rmw_mask = 32'd1 << page_reg[4:0];

    // one restoring step of hint modulo word count
    assign rem_sh  = {rem_reg, dvd_reg[AW-1]};
    assign rem_sub = rem_sh - {1'b0, nwords};

    assign chk_bit = lowest_clear(rd_data_reg);
    assign chk_pg  = {chk_idx_reg, chk_bit};
    assign chk_fit = (rd_data_reg != FULL_WORD) && (21'(chk_pg) < 21'(count_eff));
    assign issue   = (iss_cnt_reg < nwords);

    always_comb begin
        state_next     = state_reg;
        count_next     = cfg_wr_en ? cfg_wr_data : count_reg;
        hint_next      = hint_reg;
        op_next        = op_reg;
        page_next      = page_reg;
        clr_idx_next   = clr_idx_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        mod_cnt_next   = mod_cnt_reg;
        iss_idx_next   = iss_idx_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_idx_next   = chk_idx_reg;
        chk_cnt_next   = chk_cnt_reg;
        rd_vld_next    = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = rmw_word;
        wr_en    = 1'b0;
        wr_addr  = rmw_word;
        wr_data  = rd_data_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = FULL_WORD;
                if (clr_idx_reg == AW'(WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
                else begin
                    clr_idx_next = clr_idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op_next   = in_data.op;
                    page_next = in_data.page_number;
                    res_next  = '0;
                    unique case (in_data.op)
                        OP_FREE, OP_MARK: begin
                            if (in_data.page_number >= {4'd0, count_eff}) begin
                                res_next.out_of_range = 1'b1;
                                state_next            = ST_FINISH;
                            end
                            else begin
                                state_next = ST_RD;
                            end
                        end
                        OP_ALLOC: begin
                            if (nwords == '0) begin
                                state_next = ST_FINISH;
                            end
                            else begin
                                dvd_next     = hint_reg;
                                rem_next     = '0;
                                mod_cnt_next = '0;
                                state_next   = ST_MOD;
                            end
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (rem_sub[NW_W]) begin
                    rem_next = NW_W'(rem_sh);
                end
                else begin
                    rem_next = NW_W'(rem_sub);
                end
                dvd_next     = dvd_reg << 1;
                mod_cnt_next = mod_cnt_reg + MC_W'(1);
                if (mod_cnt_reg == MC_W'(AW - 1)) begin
                    iss_idx_next = AW'(rem_next);
                    iss_cnt_next = '0;
                    chk_cnt_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // reads run one word ahead of the check
                rd_en        = issue;
                rd_addr      = iss_idx_reg;
                rd_vld_next  = issue;
                chk_idx_next = iss_idx_reg;
                if (issue) begin
                    iss_cnt_next = iss_cnt_reg + NW_W'(1);
                    if (NW_W'(iss_idx_reg) == nwords_last) begin
                        iss_idx_next = '0;
                    end
                    else begin
                        iss_idx_next = iss_idx_reg + AW'(1);
                    end
                end
                if (rd_vld_reg) begin
                    if (chk_fit) begin
                        wr_en               = 1'b1;
                        wr_addr             = chk_idx_reg;
                        wr_data             = rd_data_reg | (32'd1 << chk_bit);
                        hint_next           = chk_idx_reg;
                        res_next            = '0;
                        res_next.alloc_ok   = 1'b1;
                        res_next.alloc_page = 15'(chk_pg);
                        rd_vld_next         = 1'b0;
                        state_next          = ST_FINISH;
                    end
                    else begin
                        chk_cnt_next = chk_cnt_reg + NW_W'(1);
                        if (chk_cnt_reg == nwords_last) begin
                            res_next    = '0;
                            rd_vld_next = 1'b0;
                            state_next  = ST_FINISH;
                        end
                    end
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                wr_en = 1'b1;
                if (op_reg == OP_FREE) begin
                    wr_data = rd_data_reg & ~rmw_mask;
                    if (rmw_word < hint_reg) begin
                        hint_next = rmw_word;
                    end
                end
                else begin
                    wr_data = rd_data_reg | rmw_mask;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_CLEAR;
            count_reg     <= COUNT_RESET;
            hint_reg      <= '0;
            op_reg        <= '0;
            page_reg      <= '0;
            clr_idx_reg   <= '0;
            dvd_reg       <= '0;
            rem_reg       <= '0;
            mod_cnt_reg   <= '0;
            iss_idx_reg   <= '0;
            iss_cnt_reg   <= '0;
            chk_idx_reg   <= '0;
            chk_cnt_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            hint_reg      <= hint_next;
            op_reg        <= op_next;
            page_reg      <= page_next;
            clr_idx_reg   <= clr_idx_next;
            dvd_reg       <= dvd_next;
            rem_reg       <= rem_next;
            mod_cnt_reg   <= mod_cnt_next;
            iss_idx_reg   <= iss_idx_next;
            iss_cnt_reg   <= iss_cnt_next;
            chk_idx_reg   <= chk_idx_next;
            chk_cnt_reg   <= chk_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/bpanf_checker.sv -----
// port-level checker for the next-fit page allocator, bound to the top level
// depends on bpanf_pkg and bitmap_page_allocator_next_fit_assert.svh
`include "bitmap_page_allocator_next_fit_assert.svh"

module bpanf_checker
    import bpanf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input bpanf_out_t out_data
);

    // a stalled result holds
    `BPANF_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && !out_ready,
        out_valid && $stable(out_data),
        "result changed while stalled")

    // a successful allocate never reports a range error
    `BPANF_ASSERT_NOW(a_ok_not_oor, clk, rst_n,
        out_valid && out_data.alloc_ok,
        !out_data.out_of_range,
        "alloc_ok with out_of_range")

    // a failed or non-allocate request carries page zero
    `BPANF_ASSERT_NOW(a_fail_page_zero, clk, rst_n,
        out_valid && !out_data.alloc_ok,
        out_data.alloc_page == 15'd0,
        "page set without alloc_ok")

endmodule

bind bitmap_page_allocator_next_fit bpanf_checker u_bpanf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- tb/bitmap_page_allocator_next_fit_tb.sv -----
// self-checking testbench for the next-fit bitmap page allocator
// depends on bpanf_pkg and bitmap_page_allocator_next_fit; keeps its own bitmap and hint
// and checks every result against them, with random idling on both channels
module bitmap_page_allocator_next_fit_tb;
    import bpanf_pkg::*;

    localparam int          MAP_WORDS   = DEF_MAX_PAGES / WORD_BITS;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int          SETTLE      = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    bpanf_in_t   in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bpanf_out_t  out_data;

    // mirror of the allocator state
    logic [31:0] model_bitmap [MAP_WORDS];
    int unsigned model_hint;
    logic [15:0] model_count;

    bpanf_out_t  pending_results[$];
    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned n_requests;
    int unsigned n_granted;
    int unsigned n_flagged;
    int unsigned n_settings;
    logic [1:0]  stall_mode = 2'd0;
    logic [5:0]  stall_phase = 6'd0;

    bitmap_page_allocator_next_fit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bpanf_out_t serve_page_request(input bpanf_in_t req);
        bpanf_out_t  res;
        int unsigned live;
        int unsigned nwords;
        int unsigned start;
        int unsigned wi;
        int unsigned b;
        int unsigned pg;
        logic [31:0] w;
        bit          found;
        res    = '0;
        found  = 1'b0;
        live   = (model_count > DEF_MAX_PAGES) ? DEF_MAX_PAGES : model_count;
        nwords = (live + WORD_BITS - 1) / WORD_BITS;
        if (req.op == OP_FREE || req.op == OP_MARK)
        begin
            if (req.page_number >= live)
                res.out_of_range = 1'b1;
            else
            begin
                wi = req.page_number / WORD_BITS;
                b  = req.page_number % WORD_BITS;
                if (req.op == OP_FREE)
                begin
                    model_bitmap[wi][b] = 1'b0;
                    if (wi < model_hint)
                        model_hint = wi;
                end
                else
                    model_bitmap[wi][b] = 1'b1;
            end
        end
        else if (req.op == OP_ALLOC && nwords != 0)
        begin
            // circular scan from the hint, wrapped into the live word range
            start = model_hint % nwords;
            for (int i = 0; i < nwords && !found; i++)
            begin
                wi = (start + i) % nwords;
                w  = model_bitmap[wi];
                if (w != FULL_WORD)
                begin
                    b = 0;
                    while (w[b])
                        b++;
                    pg = wi * WORD_BITS + b;
                    // a clear bit past the page count does not count as free
                    if (pg < live)
                    begin
                        model_bitmap[wi][b] = 1'b1;
                        model_hint          = wi;
                        res.alloc_ok        = 1'b1;
                        res.alloc_page      = pg[14:0];
                        found               = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // request and result monitor: predicts on acceptance, checks in order
    always @(posedge clk)
    begin : monitor
        bpanf_out_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", pending_results.size());
            $display("bitmap_page_allocator_next_fit regression: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_results.push_back(serve_page_request(in_data));
                n_requests++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, alloc_page", out_data.alloc_page, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.alloc_ok !== want.alloc_ok)
                        report_mismatch("alloc_ok", out_data.alloc_ok, want.alloc_ok);
                    if (out_data.alloc_page !== want.alloc_page)
                        report_mismatch("alloc_page", out_data.alloc_page, want.alloc_page);
                    if (out_data.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", out_data.out_of_range,
                                        want.out_of_range);
                    if (want.alloc_ok)
                        n_granted++;
                    if (want.out_of_range)
                        n_flagged++;
                end
            end
        end
    end

    // receiver stalls: a new random mode is picked each time the phase counter wraps
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 6'd1;
        if (stall_phase == 6'd0)
            stall_mode <= 2'($urandom_range(0, 3));
        case (stall_mode)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= stall_phase[2];
        endcase
    end

    // valid is left high on return so back-to-back requests need no second assignment
    task automatic send_request(input logic [1:0] op, input logic [19:0] page);
        bpanf_in_t req;
        req.op          = op;
        req.page_number = page;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_page_count(input logic [15:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        model_count = value;
        n_settings++;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_request();
        int unsigned live;
        int unsigned pick;
        logic [1:0]  op;
        logic [19:0] page;
        live = (model_count > DEF_MAX_PAGES) ? DEF_MAX_PAGES : model_count;
        pick = $urandom_range(0, 99);
        page = (live == 0) ? 20'($urandom) : 20'($urandom_range(0, live - 1));
        if (pick < 36)
            op = OP_FREE;
        else if (pick < 50)
            op = OP_MARK;
        else if (pick < 92)
            op = OP_ALLOC;
        else if (pick < 95)
            op = OP_UNUSED;
        else
        begin
            // full-width page number, nearly always past the count
            op   = ($urandom_range(0, 1) != 0) ? OP_MARK : OP_FREE;
            page = 20'($urandom);
        end
        send_request(op, page);
    endtask

    // full bitmap after reset, then the first and last page freed and taken back
    task automatic test_reset_state();
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd0);
        send_request(OP_FREE, 20'd32767);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_ALLOC, 20'd0);
    endtask

    task automatic test_range_limits();
        send_request(OP_FREE, 20'd32768);
        send_request(OP_MARK, 20'hFFFFF);
        send_request(OP_MARK, 20'd32767);
    endtask

    task automatic test_unused_op();
        send_request(OP_UNUSED, 20'hFFFFF);
        send_request(OP_UNUSED, 20'd0);
    endtask

    task automatic test_count_extremes();
        write_page_count(16'd0);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd0);
        send_request(OP_MARK, 20'd0);
        // above the page limit the count saturates
        write_page_count(16'hFFFF);
        send_request(OP_FREE, 20'd32767);
        send_request(OP_FREE, 20'd40000);
        send_request(OP_ALLOC, 20'd0);
    endtask

    // hint left high by a full-size scan, then a count ending mid-word
    task automatic test_partial_word();
        write_page_count(16'd40);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd39);
        send_request(OP_ALLOC, 20'd0);
        write_page_count(16'd64);
        send_request(OP_FREE, 20'd45);
        write_page_count(16'd40);
        send_request(OP_ALLOC, 20'd0);
        send_request(OP_FREE, 20'd45);
    endtask

    task automatic test_random_traffic();
        logic [15:0] settings [10];
        settings = '{16'd37, 16'd32, 16'd300, 16'd1, 16'd2048,
                     16'd32768, 16'd100, 16'hFFFF, 16'd64, 16'd5000};
        foreach (settings[s])
        begin
            write_page_count(settings[s]);
            repeat (80)
            begin
                if ($urandom_range(0, 59) == 0)
                    wait_for_results();
                send_random_request();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        foreach (model_bitmap[i])
            model_bitmap[i] = FULL_WORD;
        model_hint  = 0;
        model_count = COUNT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_range_limits();
        test_unused_op();
        test_count_extremes();
        test_partial_word();
        test_random_traffic();
        wait_for_results();

        if (pending_results.size() != 0)
            report_mismatch("results never returned", 0, pending_results.size());
        $display("%0d requests over %0d page count settings, down to zero and past the limit",
                 n_requests, n_settings);
        $display("%0d pages granted, %0d requests flagged out of range", n_granted, n_flagged);
        if (error_count == 0)
            $display("bitmap_page_allocator_next_fit regression: pass");
        else
            $display("bitmap_page_allocator_next_fit regression: fail");
        $finish;
    end

endmodule
